// File: hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command-line tokenizer
// Result kinds, entry capacity, counter widths and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CHAR_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int NUM_W   = 31;
  localparam int TOTAL_W = 5;

  // tdata widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = SLOT_W + CHAR_W + NUM_W + 2 * TOTAL_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [NUM_W-1:0] VALUE_MAX = {NUM_W{1'b1}};
  localparam int RADIX = 10;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_VIS_LO = 8'h21;
  localparam logic [CHAR_W-1:0] CH_VIS_HI = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

  typedef enum logic [1:0] {
    KIND_CMD = 2'd0,
    KIND_NUM = 2'd1,
    KIND_SUM = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_W-1:0]    slot;
    logic [CHAR_W-1:0]    char_value;
    logic [NUM_W-1:0]     number_value;
    logic [TOTAL_W-1:0]   command_total;
    logic [TOTAL_W-1:0]   number_total;
    logic                 dropped;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/command_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_top: command-line byte tokenizer
// Uppercases letters and emits visible non-digit characters as command
// entries, folds decimal digit runs into saturated numbers and closes each
// line with a summary of both counts.
//
//   channel | dir | tdata                              | tuser | tlast
//   in_     | in  | char_code                          | -     | end_of_line
//   out_    | out | slot, char_value, number_value,    | kind  | last
//           |     | command_total, number_total,       |       |
//           |     | dropped                            |       |
//
// A byte is decoded in the cycle it is accepted; its results (zero to three)
// go into a three-entry result register that drives the output one beat per
// cycle while out_tready is high. The single output port sets the rate, so
// bytes with at most one result flow at one per cycle while out_tready is high.
// A stalled output holds the result register and deasserts in_tready.
// Synchronous active-low reset clears the line state and the result count.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer_top
  import clt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_code
  input  wire logic                  in_tlast,   // end_of_line

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] slot, [11:4] char_value,
                                                 // [42:12] number_value,
                                                 // [47:43] command_total,
                                                 // [52:48] number_total,
                                                 // [53] dropped, rest zero
  output logic [1:0]                 out_tuser,  // [1:0] kind
  output logic                       out_tlast   // last
);

  // line state
  logic               run_r, run_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   ccnt_r, ccnt_nxt;
  logic [CNT_W-1:0]   ncnt_r, ncnt_nxt;
  logic               term_r, term_nxt;

  // result register
  result_t            res_r [3];
  result_t            res_nxt [3];
  logic [1:0]         cnt_r, cnt_nxt;

  logic               in_acc, out_pop;

  // decode
  logic [CHAR_W-1:0]  ch;
  logic               live, is_digit, is_lower, is_visible;
  logic [NUM_W+3:0]   prod, sum_v;
  logic [NUM_W-1:0]   acc_after;
  logic               run_after, close_now, close_eol, has_num, has_cmd;
  logic [NUM_W-1:0]   num_val;
  logic               num_drop, cmd_drop;
  logic [CNT_W-1:0]   ncnt_after, ccnt_after;
  logic [SLOT_W-1:0]  num_slot, cmd_slot;
  logic [CHAR_W-1:0]  cmd_char;
  result_t            r_num, r_cmd, r_sum;
  result_t            list [3];
  logic [1:0]         n_res;

  assign ch       = in_tdata[CHAR_W-1:0];
  assign live     = !term_r;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_lower = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);
  assign is_visible = (ch >= CH_VIS_LO) && (ch <= CH_VIS_HI);

  // acc * 10 as shift-add, then add the digit and saturate
  assign prod  = run_r ? (({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)) : '0;
  assign sum_v = prod + {{(NUM_W+4-4){1'b0}}, 4'(ch - CH_ZERO)};

  always_comb begin
    if (live && is_digit) begin
      run_after = 1'b1;
      acc_after = (sum_v > {4'd0, VALUE_MAX}) ? VALUE_MAX : sum_v[NUM_W-1:0];
    end else if (live) begin
      run_after = 1'b0;
      acc_after = '0;
    end else begin
      run_after = run_r;
      acc_after = acc_r;
    end
  end

  // a number closes either on a non-digit byte or at end of line; never both
  assign close_now = live && !is_digit && run_r;
  assign close_eol = in_tlast && run_after;
  assign has_num   = close_now || close_eol;
  assign num_val   = close_now ? acc_r : acc_after;
  assign num_drop  = (32'(ncnt_r) >= MAX_ENTRIES);
  assign num_slot  = num_drop ? '0 : SLOT_W'(ncnt_r);
  assign ncnt_after = (has_num && !num_drop) ? ncnt_r + 1'b1 : ncnt_r;

  assign has_cmd   = live && !is_digit && is_visible;
  assign cmd_char  = is_lower ? ch - CASE_OFS : ch;
  assign cmd_drop  = (32'(ccnt_r) >= MAX_ENTRIES);
  assign cmd_slot  = cmd_drop ? '0 : SLOT_W'(ccnt_r);
  assign ccnt_after = (has_cmd && !cmd_drop) ? ccnt_r + 1'b1 : ccnt_r;

  always_comb begin
    r_num = '{kind: KIND_NUM, slot: num_slot, char_value: '0, number_value: num_val,
              command_total: TOTAL_W'(ccnt_r), number_total: TOTAL_W'(ncnt_after),
              dropped: num_drop, last: 1'b0};
    r_cmd = '{kind: KIND_CMD, slot: cmd_slot, char_value: cmd_char, number_value: '0,
              command_total: TOTAL_W'(ccnt_after), number_total: TOTAL_W'(ncnt_after),
              dropped: cmd_drop, last: 1'b0};
    r_sum = '{kind: KIND_SUM, slot: '0, char_value: '0, number_value: '0,
              command_total: TOTAL_W'(ccnt_after), number_total: TOTAL_W'(ncnt_after),
              dropped: 1'b0, last: 1'b0};
  end

  // pack present results in order: number, command, summary
  always_comb begin
    list[0] = '0;
    list[1] = '0;
    list[2] = '0;
    n_res   = 2'd0;
    if (has_num) begin
      list[n_res] = r_num;
      n_res       = n_res + 2'd1;
    end
    if (has_cmd) begin
      list[n_res] = r_cmd;
      n_res       = n_res + 2'd1;
    end
    if (in_tlast) begin
      list[n_res] = r_sum;
      n_res       = n_res + 2'd1;
    end
    if (n_res != 2'd0) begin
      list[n_res - 2'd1].last = 1'b1;
    end
  end

  // handshake
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_pop    = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    run_nxt  = run_r;
    acc_nxt  = acc_r;
    ccnt_nxt = ccnt_r;
    ncnt_nxt = ncnt_r;
    term_nxt = term_r;
    if (in_acc) begin
      if (in_tlast) begin
        run_nxt  = 1'b0;
        acc_nxt  = '0;
        ccnt_nxt = '0;
        ncnt_nxt = '0;
        term_nxt = 1'b0;
      end else begin
        run_nxt  = run_after;
        acc_nxt  = acc_after;
        ccnt_nxt = ccnt_after;
        ncnt_nxt = ncnt_after;
        term_nxt = term_r || (live && (ch == CH_NUL));
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      res_nxt = list;
      cnt_nxt = n_res;
    end else if (out_pop) begin
      // advance the queue by one beat
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      acc_r  <= '0;
      ccnt_r <= '0;
      ncnt_r <= '0;
      term_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      run_r  <= run_nxt;
      acc_r  <= acc_nxt;
      ccnt_r <= ccnt_nxt;
      ncnt_r <= ncnt_nxt;
      term_r <= term_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tuser = res_r[0].kind;
  assign out_tlast = res_r[0].last;
  assign out_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                      res_r[0].dropped,
                      res_r[0].number_total,
                      res_r[0].command_total,
                      res_r[0].number_value,
                      res_r[0].char_value,
                      res_r[0].slot};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> in_tready)
    else $error("input stalled with empty result register");

  a_last_only_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 2'd1) |-> !res_r[0].last)
    else $error("last flag ahead of queued results");

  a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_SUM)) |-> out_tlast)
    else $error("summary beat without last");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ccnt_r) <= MAX_ENTRIES) && (32'(ncnt_r) <= MAX_ENTRIES))
    else $error("entry counter beyond capacity");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (ccnt_r == '0) && (ncnt_r == '0) && !run_r && !term_r)
    else $error("line state not cleared after end of line");

endmodule

`default_nettype wire
